// ----- hw/rtl/bdll_pkg.sv -----
// shared types, codes and defaults for the bounded doubly linked list
`timescale 1ns / 1ps
`default_nettype none

package bdll_pkg;

  localparam int BDLL_CAPACITY   = 32;
  localparam int BDLL_DATA_WIDTH = 32;

  // cell index width, wide enough for the largest supported capacity
  localparam int IDX_W     = 6;
  localparam int ITEM_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 6;
  localparam int STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_FWD_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_BACK_READ = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd3;
  localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_HEAD  = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd6;
  localparam logic [OP_W-1:0] OP_DEL_TAIL  = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROT_LEFT,
    CMD_ROT_RIGHT
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [IDX_W-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_doubly_linked_list_top.sv -----
// top level of the bounded doubly linked list: cell chain, control and output register
//
// The list is held in order in a chain of CAPACITY cells, element n in cell n-1. Inserts
// and deletes at head, tail or a one-based position shift the cells behind the key together,
// so edits are taken one item per cycle outside reads while the output register is free,
// and each shows its status in the next cycle. A forward or backward read rotates the whole
// chain once around, one step per cycle while the output is not stalled, and emits an item
// each time a stored element passes the read tap (cell 0 forward, the last cell backward);
// the next item is taken once the rotation is back at its start. A read of an empty list and
// every edit give one item with last set. Status is carried in m_axis_tuser.
`timescale 1ns / 1ps
`default_nettype none

module bounded_doubly_linked_list_top
  import bdll_pkg::*;
#(
  parameter int CAPACITY   = BDLL_CAPACITY,
  parameter int DATA_WIDTH = BDLL_DATA_WIDTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // value [31:0], position [37:32], zero [39:38]
  input  wire  [2:0]  s_axis_tuser,   // operation [2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // item_value [31:0], element_count [37:32], zero [39:38]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(CAPACITY);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 1);
  localparam logic [CMP_W-1:0]  CMP_ONE   = CMP_W'(1);
  localparam logic [SUM_W-1:0]  SUM_CAP   = SUM_W'(CAPACITY);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  // input unpacking
  logic [OP_W-1:0]       in_op;
  logic [ITEM_W-1:0]     in_value;
  logic [POS_W-1:0]      in_pos;
  logic [DATA_WIDTH-1:0] in_word;

  assign in_op    = s_axis_tuser;
  assign in_value = s_axis_tdata[ITEM_W-1:0];
  assign in_pos   = s_axis_tdata[ITEM_W+POS_W-1:ITEM_W];

  // control state
  logic              state_q, state_d;
  logic              dir_q, dir_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  len_q, len_d;

  // output register
  logic                 out_vld_q;
  logic [ITEM_W-1:0]    out_item_q;
  logic                 out_last_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [CNT_OUT_W-1:0] out_count_q;

  logic              out_free;
  logic              in_fire;
  logic              full;
  logic              empty;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  len_x;
  logic              ins_pos_ok;
  logic              del_pos_ok;
  logic [IDX_W-1:0]  pos_key;

  logic [DATA_WIDTH-1:0] tap_word;
  logic [ITEM_W-1:0]     tap_item;
  logic                  tap_valid;
  logic                  tap_last;
  logic                  advance;

  logic              out_load;
  logic [ITEM_W-1:0] load_item;
  logic              load_last;
  logic [STAT_W-1:0] load_status;

  cell_ctl_t             ctl;
  logic [DATA_WIDTH-1:0] cell_val [CAPACITY];

  // word sizing between the stream and the cells
  generate
    if (DATA_WIDTH >= ITEM_W) begin : g_wide
      assign in_word  = DATA_WIDTH'($signed(in_value));
      assign tap_item = tap_word[ITEM_W-1:0];
    end else begin : g_narrow
      assign in_word  = in_value[DATA_WIDTH-1:0];
      assign tap_item = ITEM_W'($signed(tap_word));
    end
  endgenerate

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign full       = (len_q == CNT_FULL);
  assign empty      = (len_q == '0);
  assign pos_x      = CMP_W'(in_pos);
  assign len_x      = CMP_W'(len_q);
  assign ins_pos_ok = (pos_x >= CMP_ONE) && (pos_x <= len_x + CMP_ONE);
  assign del_pos_ok = (pos_x >= CMP_ONE) && (pos_x <= len_x);
  assign pos_key    = IDX_W'(pos_x - CMP_ONE);

  // read tap
  assign tap_word  = dir_q ? cell_val[CAPACITY-1] : cell_val[0];
  assign tap_valid = dir_q ? ((SUM_W'(step_q) + SUM_W'(len_q)) >= SUM_CAP)
                           : (CNT_W'(step_q) < len_q);
  assign tap_last  = dir_q ? (step_q == STEP_LAST) : ((CNT_W'(step_q) + CNT_ONE) == len_q);
  assign advance   = (state_q == ST_STREAM) && (!tap_valid || out_free);

  always_comb begin
    state_d     = state_q;
    dir_d       = dir_q;
    step_d      = step_q;
    len_d       = len_q;
    ctl.cmd     = CMD_HOLD;
    ctl.key     = '0;
    out_load    = 1'b0;
    load_item   = '0;
    load_last   = 1'b1;
    load_status = STAT_OK;
    if (in_fire) begin
      unique case (in_op)
        OP_FWD_READ, OP_BACK_READ: begin
          if (empty) begin
            out_load    = 1'b1;
            load_status = STAT_EMPTY;
          end else begin
            state_d = ST_STREAM;
            step_d  = '0;
            dir_d   = (in_op == OP_BACK_READ);
          end
        end
        OP_INS_HEAD: begin
          out_load = 1'b1;
          if (full) begin
            load_status = STAT_FULL;
          end else begin
            ctl.cmd = CMD_INS;
            ctl.key = '0;
            len_d   = len_q + CNT_ONE;
          end
        end
        OP_INS_POS: begin
          out_load = 1'b1;
          if (full) begin
            load_status = STAT_FULL;
          end else if (!ins_pos_ok) begin
            load_status = STAT_BAD_POS;
          end else begin
            ctl.cmd = CMD_INS;
            ctl.key = pos_key;
            len_d   = len_q + CNT_ONE;
          end
        end
        OP_INS_TAIL: begin
          out_load = 1'b1;
          if (full) begin
            load_status = STAT_FULL;
          end else begin
            ctl.cmd = CMD_INS;
            ctl.key = IDX_W'(len_q);
            len_d   = len_q + CNT_ONE;
          end
        end
        OP_DEL_HEAD: begin
          out_load = 1'b1;
          if (empty) begin
            load_status = STAT_EMPTY;
          end else begin
            ctl.cmd = CMD_DEL;
            ctl.key = '0;
            len_d   = len_q - CNT_ONE;
          end
        end
        OP_DEL_POS: begin
          out_load = 1'b1;
          if (empty) begin
            load_status = STAT_EMPTY;
          end else if (!del_pos_ok) begin
            load_status = STAT_BAD_POS;
          end else begin
            ctl.cmd = CMD_DEL;
            ctl.key = pos_key;
            len_d   = len_q - CNT_ONE;
          end
        end
        OP_DEL_TAIL: begin
          out_load = 1'b1;
          if (empty) begin
            load_status = STAT_EMPTY;
          end else begin
            ctl.cmd = CMD_DEL;
            ctl.key = IDX_W'(len_q - CNT_ONE);
            len_d   = len_q - CNT_ONE;
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end else if (advance) begin
      ctl.cmd = dir_q ? CMD_ROT_RIGHT : CMD_ROT_LEFT;
      if (tap_valid) begin
        out_load  = 1'b1;
        load_item = tap_item;
        load_last = tap_last;
      end
      if (step_q == STEP_LAST) begin
        state_d = ST_IDLE;
      end else begin
        step_d = step_q + STEP_ONE;
      end
    end
  end

  // cell chain, closed into a ring for rotation
  generate
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      bdll_cell #(
        .INDEX      (j),
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk_i         (clk_i),
        .ctl_i         (ctl),
        .new_value_i   (in_word),
        .left_value_i  (cell_val[(j + CAPACITY - 1) % CAPACITY]),
        .right_value_i (cell_val[(j + 1) % CAPACITY]),
        .value_o       (cell_val[j])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dir_q     <= 1'b0;
      step_q    <= '0;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      step_q  <= step_d;
      len_q   <= len_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q   <= load_item;
      out_last_q   <= load_last;
      out_status_q <= load_status;
      out_count_q  <= CNT_OUT_W'(len_d);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_count_q, out_item_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_FULL)
    else $error("list length above capacity");

  a_edit_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op != OP_FWD_READ) && (in_op != OP_BACK_READ)) |=> m_axis_tvalid)
    else $error("edit gave no result item");

  a_read_starts_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !empty && ((in_op == OP_FWD_READ) || (in_op == OP_BACK_READ)))
      |=> (state_q == ST_STREAM) && (step_q == '0))
    else $error("read of a filled list did not start the rotation");

  a_stream_keeps_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |=> $stable(len_q))
    else $error("length changed during a read");

endmodule

`default_nettype wire

// ----- hw/rtl/bdll_cell.sv -----
// one storage cell of the list chain, shifting or rotating with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module bdll_cell
  import bdll_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = BDLL_DATA_WIDTH
) (
  input  wire                  clk_i,
  input  wire cell_ctl_t       ctl_i,
  input  wire [DATA_WIDTH-1:0] new_value_i,
  input  wire [DATA_WIDTH-1:0] left_value_i,
  input  wire [DATA_WIDTH-1:0] right_value_i,
  output logic [DATA_WIDTH-1:0] value_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.cmd)
      CMD_HOLD: value_d = value_q;
      CMD_INS: begin
        if (MY_IDX > ctl_i.key) begin
          value_d = left_value_i;
        end else if (MY_IDX == ctl_i.key) begin
          value_d = new_value_i;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= ctl_i.key) begin
          value_d = right_value_i;
        end
      end
      CMD_ROT_LEFT:  value_d = right_value_i;
      CMD_ROT_RIGHT: value_d = left_value_i;
      default:       value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire
